[src/gfw_pkg.sv]
// ----------------------------------------------------------------------------
// gfw_pkg: shared types and constants for the glass transfer weight pipeline
// Fixed-point formats, cell chain lengths and the structs handed between cells.
// ----------------------------------------------------------------------------
package gfw_pkg;

    // cosine fraction bits at the ports (Q1.COS_FRAC_BITS); internal cosines are Q1.30
    localparam int COS_FRAC_BITS = 15;
    localparam int C_SHIFT       = 30 - COS_FRAC_BITS;

    localparam int IOR_W  = 15;
    localparam int COS_W  = 16;
    localparam int INT_W  = 16;
    localparam int OUT_W  = 20;
    localparam int REFL_W = 17;

    localparam logic [IOR_W-1:0]  IOR_RESET = 15'd12288;
    localparam logic [IOR_W-1:0]  IOR_MIN   = 15'd8192;
    localparam logic [COS_W-1:0]  ONE_F     = 16'(1 << COS_FRAC_BITS);
    localparam logic [30:0]       Q30_ONE   = 31'h4000_0000;
    localparam logic [REFL_W-1:0] REFL_ONE  = 17'd65536;
    localparam logic [OUT_W-1:0]  OUT_MAX   = 20'hF_FFFF;

    // cell chain lengths (one result bit per cell)
    localparam int DIV_T_STEPS = 31;
    localparam int SQRT_STEPS  = 31;
    localparam int DIV_R_STEPS = 31;
    localparam int DIV_W_STEPS = 17;

    // one restoring division step: partial remainder, unshifted dividend bits,
    // quotient so far, divisor
    typedef struct packed {
        logic [34:0] rem;
        logic [31:0] dvd;
        logic [31:0] quo;
        logic [33:0] den;
    } t_div;

    // one digit-by-digit square root step
    typedef struct packed {
        logic [33:0] rem;
        logic [30:0] root;
        logic [61:0] rad;
    } t_sqrt;

    // item context carried beside the arithmetic cells
    typedef struct packed {
        logic        vld;
        logic [30:0] c30;
        logic        in_g;
        logic        out_g;
        logic [15:0] inten;
        logic [14:0] n;
        logic [29:0] n2;
        logic [30:0] s2;
        logic [30:0] diff;
        logic        tir;
        logic [30:0] ca;
        logic [30:0] cg;
        logic [31:0] m1;
        logic [31:0] m2;
        logic        zero;
        logic [30:0] r1;
        logic [30:0] r2;
        logic [16:0] r16;
        logic [20:0] wmul;
        logic [19:0] w;
    } t_side;

    // finished result item
    typedef struct packed {
        logic        vld;
        logic [19:0] io;
        logic [19:0] w;
        logic [16:0] r16;
        logic [15:0] other;
        logic        tir;
        logic        zero;
    } t_res;

endpackage

[src/gfw_div_cell.sv]
// ----------------------------------------------------------------------------
// gfw_div_cell: one restoring division step
// Shift in one dividend bit, trial-subtract the divisor, append one quotient bit.
// ----------------------------------------------------------------------------
module gfw_div_cell
    import gfw_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_q
);

    t_div        r_q;
    logic [34:0] w_trial;
    logic [34:0] w_den;
    logic        w_ge;

    assign w_trial = {i_d.rem[33:0], i_d.dvd[31]};
    assign w_den   = {1'b0, i_d.den};
    assign w_ge    = (w_trial >= w_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q.rem <= w_ge ? (w_trial - w_den) : w_trial;
            r_q.dvd <= {i_d.dvd[30:0], 1'b0};
            r_q.quo <= {i_d.quo[30:0], w_ge};
            r_q.den <= i_d.den;
        end
    end

    assign o_q = r_q;

endmodule

[src/gfw_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// gfw_sqrt_cell: one floor square root step
// Bring down two radicand bits, compare against 4*root+1, append one root bit.
// ----------------------------------------------------------------------------
module gfw_sqrt_cell
    import gfw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_sqrt i_d,
    output t_sqrt o_q
);

    t_sqrt       r_q;
    logic [33:0] w_r4;
    logic [33:0] w_trial;
    logic        w_ge;

    assign w_r4    = {i_d.rem[31:0], i_d.rad[61:60]};
    assign w_trial = {1'b0, i_d.root, 2'b01};
    assign w_ge    = (w_r4 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q.rem  <= w_ge ? (w_r4 - w_trial) : w_r4;
            r_q.root <= {i_d.root[29:0], w_ge};
            r_q.rad  <= {i_d.rad[59:0], 2'b00};
        end
    end

    assign o_q = r_q;

endmodule

[src/glass_fresnel_transfer_weight.sv]
// ----------------------------------------------------------------------------
// glass_fresnel_transfer_weight: unpolarized Fresnel weight at a glass interface
// Snell cosine, reflectance R and transfer weight, then scale the intensity.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+---------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: cos, intensity
//            |           |                              | tuser: in/out glass flags
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: io, w, R, cos other
//            |           |                              | tuser: tir, degenerate
//  cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_data: index n Q2.13
//
//  One item enters per cycle while the output is not stalled. The pipeline is
//  built from four chains of one-bit cells: a 31-step divider for the air-side
//  sin^2/n^2, a 31-step square root for the other cosine, two 31-step dividers
//  for the Fresnel ratios and a 17-step divider for (1-R)/n^2.
//  A stalled output holds the whole pipeline in place (single enable); s_axis_tready
//  drops only while a result waits and m_axis_tready is low.
//  Reset (synchronous, active low) clears the valid bits and loads n = 1.5.
//  The index register is always ready; write it only with the pipeline empty.
//
module glass_fresnel_transfer_weight
    import gfw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] cos_incoming, [31:16] intensity_in
    input  logic [1:0]  s_axis_tuser,  // [0] incoming_in_glass, [1] outgoing_in_glass
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // [19:0] intensity_out, [39:20] transfer_weight,
                                       // [56:40] reflectance, [72:57] cos_other_side,
                                       // [79:73] zero
    output logic [1:0]  m_axis_tuser   // [0] total_internal, [1] degenerate
);

    logic             w_en;
    logic [IOR_W-1:0] r_ior;

    t_side r_s1, n_s1;
    t_side r_s2, n_s2;
    t_side n_s3, n_s4, n_s5, r_s5, n_s6, n_s7, r_s7, n_s8, r_s8, n_s9, n_s10, r_s10;
    t_res  r_out, n_out;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ior <= IOR_RESET;
        end else if (i_cfg_valid) begin
            r_ior <= i_cfg_data;
        end
    end

    // advance every stage unless a finished item is stuck at the output
    assign w_en          = !r_out.vld || m_axis_tready;
    assign s_axis_tready = w_en;

    // ---------------- stage 1: capture, clamp cosine and index ----------------
    logic [15:0] w_c_in;
    logic [15:0] w_c_cl;

    always_comb begin
        w_c_in     = s_axis_tdata[15:0];
        w_c_cl     = (w_c_in > ONE_F) ? ONE_F : w_c_in;
        n_s1       = '0;
        n_s1.vld   = s_axis_tvalid;
        n_s1.c30   = 31'(w_c_cl) << C_SHIFT;
        n_s1.in_g  = s_axis_tuser[0];
        n_s1.out_g = s_axis_tuser[1];
        n_s1.inten = s_axis_tdata[31:16];
        n_s1.n     = (r_ior < IOR_MIN) ? IOR_MIN : r_ior;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (w_en) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- stage 2: sin^2 and n^2 ----------------
    logic [61:0] w_csq;

    always_comb begin
        w_csq   = 62'(r_s1.c30) * 62'(r_s1.c30);
        n_s2    = r_s1;
        n_s2.s2 = Q30_ONE - w_csq[60:30];
        n_s2.n2 = 30'(r_s1.n) * 30'(r_s1.n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else if (w_en) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------- stage 3: glass-side n^2 sin^2, air-side divider load ----------------
    logic [60:0] w_tg;
    logic        w_tg_over;
    t_div        n_dt;

    always_comb begin
        w_tg      = 61'(r_s2.n2) * 61'(r_s2.s2);
        w_tg_over = (w_tg[60:26] >= 35'(Q30_ONE));
        n_s3      = r_s2;
        n_s3.tir  = r_s2.in_g && w_tg_over;
        n_s3.diff = w_tg_over ? 31'd0 : (Q30_ONE - {1'b0, w_tg[55:26]});
        // air side: (s2 << 26) / n2, quotient fits 31 bits
        n_dt.rem  = 35'(r_s2.s2 >> 5);
        n_dt.dvd  = {r_s2.s2[4:0], 27'd0};
        n_dt.quo  = '0;
        n_dt.den  = 34'(r_s2.n2);
    end

    t_side r_ts     [DIV_T_STEPS];
    t_div  w_dt_in  [DIV_T_STEPS];
    t_div  w_dt_out [DIV_T_STEPS];

    for (genvar gi = 0; gi < DIV_T_STEPS; gi++) begin : g_div_t
        if (gi == 0) begin : g_head
            assign w_dt_in[gi] = n_dt;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ts[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_ts[gi] <= n_s3;
                end
            end
        end else begin : g_body
            assign w_dt_in[gi] = w_dt_out[gi-1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ts[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_ts[gi] <= r_ts[gi-1];
                end
            end
        end
        gfw_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_dt_in[gi]),
            .o_q   (w_dt_out[gi])
        );
    end

    // ---------------- stage 4: radicand, square root chain ----------------
    t_sqrt n_sq;

    always_comb begin
        n_s4 = r_ts[DIV_T_STEPS-1];
        if (!n_s4.in_g) begin
            n_s4.diff = Q30_ONE - w_dt_out[DIV_T_STEPS-1].quo[30:0];
        end
        n_sq.rem  = '0;
        n_sq.root = '0;
        n_sq.rad  = {1'b0, n_s4.diff, 30'd0};
    end

    t_side r_qs     [SQRT_STEPS];
    t_sqrt w_sq_in  [SQRT_STEPS];
    t_sqrt w_sq_out [SQRT_STEPS];

    for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
        if (gi == 0) begin : g_head
            assign w_sq_in[gi] = n_sq;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_qs[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_qs[gi] <= n_s4;
                end
            end
        end else begin : g_body
            assign w_sq_in[gi] = w_sq_out[gi-1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_qs[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_qs[gi] <= r_qs[gi-1];
                end
            end
        end
        gfw_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq_in[gi]),
            .o_q   (w_sq_out[gi])
        );
    end

    // ---------------- stage 5: assign air/glass cosines, n*cos products ----------------
    logic [30:0] w_root;
    logic [45:0] w_ncg;
    logic [45:0] w_nca;

    always_comb begin
        w_root = w_sq_out[SQRT_STEPS-1].root;
        n_s5   = r_qs[SQRT_STEPS-1];
        if (n_s5.in_g) begin
            n_s5.ca = w_root;
            n_s5.cg = n_s5.c30;
        end else begin
            n_s5.ca = n_s5.c30;
            n_s5.cg = w_root;
        end
        w_ncg   = 46'(n_s5.n) * 46'(n_s5.cg);
        w_nca   = 46'(n_s5.n) * 46'(n_s5.ca);
        n_s5.m1 = w_ncg[44:13];
        n_s5.m2 = w_nca[44:13];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5.vld <= 1'b0;
        end else if (w_en) begin
            r_s5 <= n_s5;
        end
    end

    // ---------------- stage 6: Fresnel ratio dividers ----------------
    logic [32:0] w_a1, w_b1, w_a2, w_b2;
    logic [32:0] w_num1, w_den1, w_num2, w_den2;
    t_div        n_d1, n_d2;

    always_comb begin
        w_a1   = 33'(r_s5.ca);
        w_b1   = 33'(r_s5.m1);
        w_a2   = 33'(r_s5.cg);
        w_b2   = 33'(r_s5.m2);
        w_num1 = (w_a1 > w_b1) ? (w_a1 - w_b1) : (w_b1 - w_a1);
        w_den1 = w_a1 + w_b1;
        w_num2 = (w_a2 > w_b2) ? (w_a2 - w_b2) : (w_b2 - w_a2);
        w_den2 = w_a2 + w_b2;
        n_s6      = r_s5;
        n_s6.zero = (w_den1 == 33'd0) || (w_den2 == 33'd0);
        // (num << 30) / den, quotient fits 31 bits
        n_d1.rem = 35'(w_num1 >> 1);
        n_d1.dvd = {w_num1[0], 31'd0};
        n_d1.quo = '0;
        n_d1.den = 34'(w_den1);
        n_d2.rem = 35'(w_num2 >> 1);
        n_d2.dvd = {w_num2[0], 31'd0};
        n_d2.quo = '0;
        n_d2.den = 34'(w_den2);
    end

    t_side r_rs     [DIV_R_STEPS];
    t_div  w_d1_in  [DIV_R_STEPS];
    t_div  w_d1_out [DIV_R_STEPS];
    t_div  w_d2_in  [DIV_R_STEPS];
    t_div  w_d2_out [DIV_R_STEPS];

    for (genvar gi = 0; gi < DIV_R_STEPS; gi++) begin : g_div_r
        if (gi == 0) begin : g_head
            assign w_d1_in[gi] = n_d1;
            assign w_d2_in[gi] = n_d2;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rs[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_rs[gi] <= n_s6;
                end
            end
        end else begin : g_body
            assign w_d1_in[gi] = w_d1_out[gi-1];
            assign w_d2_in[gi] = w_d2_out[gi-1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rs[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_rs[gi] <= r_rs[gi-1];
                end
            end
        end
        gfw_div_cell u_cell_s (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_d1_in[gi]),
            .o_q   (w_d1_out[gi])
        );
        gfw_div_cell u_cell_p (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_d2_in[gi]),
            .o_q   (w_d2_out[gi])
        );
    end

    // ---------------- stage 7: square the ratios ----------------
    logic [30:0] w_q1, w_q2;
    logic [61:0] w_q1sq, w_q2sq;

    always_comb begin
        w_q1    = w_d1_out[DIV_R_STEPS-1].quo[30:0];
        w_q2    = w_d2_out[DIV_R_STEPS-1].quo[30:0];
        w_q1sq  = 62'(w_q1) * 62'(w_q1);
        w_q2sq  = 62'(w_q2) * 62'(w_q2);
        n_s7    = r_rs[DIV_R_STEPS-1];
        n_s7.r1 = w_q1sq[60:30];
        n_s7.r2 = w_q2sq[60:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7.vld <= 1'b0;
        end else if (w_en) begin
            r_s7 <= n_s7;
        end
    end

    // ---------------- stage 8: average and round R to Q1.16 ----------------
    logic [31:0] w_rsum;
    logic [30:0] w_r30;
    logic [31:0] w_rrnd;

    always_comb begin
        w_rsum   = 32'(r_s7.r1) + 32'(r_s7.r2);
        w_r30    = r_s7.zero ? Q30_ONE : w_rsum[31:1];
        w_rrnd   = 32'(w_r30) + 32'h0000_2000;
        n_s8     = r_s7;
        n_s8.r16 = w_rrnd[30:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8.vld <= 1'b0;
        end else if (w_en) begin
            r_s8 <= n_s8;
        end
    end

    // ---------------- stage 9: (1-R)*n^2 and (1-R)/n^2 divider load ----------------
    logic [16:0] w_t16;
    logic [47:0] w_tmul;
    logic [42:0] w_wdvd;
    t_div        n_dw;

    always_comb begin
        w_t16     = REFL_ONE - r_s8.r16;
        w_tmul    = 48'(w_t16) * 48'(r_s8.n2) + 48'h0000_0200_0000;
        n_s9      = r_s8;
        n_s9.wmul = w_tmul[46:26];
        w_wdvd    = {w_t16, 26'd0} + 43'(r_s8.n2 >> 1);
        n_dw.rem  = 35'(w_wdvd[42:17]);
        n_dw.dvd  = {w_wdvd[16:0], 15'd0};
        n_dw.quo  = '0;
        n_dw.den  = 34'(r_s8.n2);
    end

    t_side r_ws     [DIV_W_STEPS];
    t_div  w_dw_in  [DIV_W_STEPS];
    t_div  w_dw_out [DIV_W_STEPS];

    for (genvar gi = 0; gi < DIV_W_STEPS; gi++) begin : g_div_w
        if (gi == 0) begin : g_head
            assign w_dw_in[gi] = n_dw;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ws[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_ws[gi] <= n_s9;
                end
            end
        end else begin : g_body
            assign w_dw_in[gi] = w_dw_out[gi-1];
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ws[gi].vld <= 1'b0;
                end else if (w_en) begin
                    r_ws[gi] <= r_ws[gi-1];
                end
            end
        end
        gfw_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_dw_in[gi]),
            .o_q   (w_dw_out[gi])
        );
    end

    // ---------------- stage 10: pick and saturate the weight ----------------
    logic [20:0] w_wsel;

    always_comb begin
        n_s10 = r_ws[DIV_W_STEPS-1];
        if (n_s10.in_g == n_s10.out_g) begin
            w_wsel = 21'(n_s10.r16);
        end else if (n_s10.out_g) begin
            w_wsel = n_s10.wmul;
        end else begin
            w_wsel = 21'(w_dw_out[DIV_W_STEPS-1].quo[16:0]);
        end
        n_s10.w = (w_wsel > 21'(OUT_MAX)) ? OUT_MAX : w_wsel[19:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10.vld <= 1'b0;
        end else if (w_en) begin
            r_s10 <= n_s10;
        end
    end

    // ---------------- stage 11: scale intensity, round other cosine ----------------
    logic [36:0] w_io;
    logic [30:0] w_oth30;
    logic [31:0] w_oth;
    logic [16:0] w_oth_sh;

    always_comb begin
        w_io      = 37'(r_s10.inten) * 37'(r_s10.w) + 37'h0_0000_8000;
        w_oth30   = r_s10.in_g ? r_s10.ca : r_s10.cg;
        w_oth     = 32'(w_oth30) + (32'd1 << (C_SHIFT - 1));
        w_oth_sh  = 17'(w_oth >> C_SHIFT);
        n_out.vld   = r_s10.vld;
        n_out.io    = (w_io[36:16] > 21'(OUT_MAX)) ? OUT_MAX : w_io[35:16];
        n_out.w     = r_s10.w;
        n_out.r16   = r_s10.r16;
        n_out.other = (w_oth_sh > 17'(ONE_F)) ? ONE_F : w_oth_sh[15:0];
        n_out.tir   = r_s10.tir;
        n_out.zero  = r_s10.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (w_en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out.vld;
    assign m_axis_tdata  = {7'd0, r_out.other, r_out.r16, r_out.w, r_out.io};
    assign m_axis_tuser  = {r_out.zero, r_out.tir};

    // ---------------- assertions ----------------
    a_tir_cos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.vld && r_out.tir |-> r_out.other == 16'd0)
        else $error("total internal reflection with nonzero other-side cosine");

    a_tir_full_refl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.vld && r_out.tir |-> r_out.r16 == REFL_ONE)
        else $error("total internal reflection without full reflectance");

    a_degen_refl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.vld && r_out.zero |-> r_out.r16 == REFL_ONE)
        else $error("degenerate item without full reflectance");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out.vld |-> s_axis_tready)
        else $error("input stalled while output register is empty");

endmodule
